[hw/rtl/kscl_pkg.sv]
// Package for the keypad scanner code lock: scan phases, register indices,
// word structs and the key character table. No dependencies.
package kscl_pkg;

  localparam int unsigned CODE_LENGTH = 8;
  localparam int unsigned KEY_SLOTS   = 8;
  localparam int unsigned SLOT_W      = $clog2(KEY_SLOTS);

  localparam logic [3:0] LINES_IDLE = 4'hF;
  localparam logic [7:0] TIMER_MAX  = 8'hFF;
  localparam logic [1:0] LAST_ROW   = 2'd3;

  typedef enum logic [3:0] {
    PH_RELEASE  = 4'b0001,
    PH_PRESS    = 4'b0010,
    PH_DEBOUNCE = 4'b0100,
    PH_SCAN     = 4'b1000
  } phase_t;

  typedef enum logic [1:0] {
    REG_PASSCODE      = 2'd0,
    REG_RELEASE_SETTLE = 2'd1,
    REG_DEBOUNCE      = 2'd2,
    REG_ROW_SETTLE    = 2'd3
  } reg_idx_t;

  localparam logic [31:0] PASSCODE_RST       = 32'd3875312464;
  localparam logic [7:0]  RELEASE_SETTLE_RST = 8'd20;
  localparam logic [7:0]  DEBOUNCE_RST       = 8'd45;
  localparam logic [7:0]  ROW_SETTLE_RST     = 8'd5;

  typedef struct packed {
    logic [31:0] passcode;
    logic [7:0]  release_settle_ticks;
    logic [7:0]  debounce_ticks;
    logic [7:0]  row_settle_ticks;
  } cfg_t;

  typedef struct packed {
    phase_t      phase;
    logic [7:0]  tick_timer;
    logic [1:0]  column_number;
    logic [1:0]  row_number;
    logic [3:0]  key_count;
  } ctrl_t;

  typedef struct packed {
    logic [3:0] row_drive;
    logic       key_valid;
    logic [7:0] key_char;
    logic [3:0] keys_entered;
    logic       entry_done;
    logic       access_granted;
  } result_t;

  typedef struct packed {
    logic              wr_en;
    logic [SLOT_W-1:0] slot;
    logic [3:0]        key_idx;
  } key_wr_t;

  // low-active column pattern to column number; anything but a lone
  // column 0, 1 or 2 counts as column 3
  function automatic logic [1:0] decode_column(input logic [3:0] lines);
    logic [3:0] low;
    low = ~lines;
    unique case (low)
      4'b0001: decode_column = 2'd0;
      4'b0010: decode_column = 2'd1;
      4'b0100: decode_column = 2'd2;
      default: decode_column = 2'd3;
    endcase
  endfunction

  function automatic logic [7:0] key_char(input logic [3:0] idx);
    unique case (idx)
      4'd0:    key_char = 8'h31;  // 1
      4'd1:    key_char = 8'h32;  // 2
      4'd2:    key_char = 8'h33;  // 3
      4'd3:    key_char = 8'h41;  // A
      4'd4:    key_char = 8'h34;  // 4
      4'd5:    key_char = 8'h35;  // 5
      4'd6:    key_char = 8'h36;  // 6
      4'd7:    key_char = 8'h42;  // B
      4'd8:    key_char = 8'h37;  // 7
      4'd9:    key_char = 8'h38;  // 8
      4'd10:   key_char = 8'h39;  // 9
      4'd11:   key_char = 8'h43;  // C
      4'd12:   key_char = 8'h2A;  // *
      4'd13:   key_char = 8'h30;  // 0
      4'd14:   key_char = 8'h23;  // #
      default: key_char = 8'h44;  // D
    endcase
  endfunction

endpackage

[hw/rtl/kscl_key_store.sv]
// Entered key store and passcode compare for the code lock.
// Depends on kscl_pkg.
module kscl_key_store (
  input  logic             clk,
  input  logic             wr_fire,
  input  kscl_pkg::key_wr_t wr,
  input  logic [31:0]      passcode,
  output logic             match
);

  logic [3:0] keys_r [kscl_pkg::KEY_SLOTS];

  always_ff @(posedge clk) begin
    if (wr_fire) begin
      keys_r[wr.slot] <= wr.key_idx;
    end
  end

  // the key being written this word takes part in the compare directly
  always_comb begin
    logic [3:0] entry;
    match = 1'b1;
    for (int k = 0; k < kscl_pkg::CODE_LENGTH; k++) begin
      entry = (wr.slot == kscl_pkg::SLOT_W'(k)) ? wr.key_idx : keys_r[k];
      if (entry != passcode[4*k +: 4]) begin
        match = 1'b0;
      end
    end
  end

endmodule

[hw/rtl/kscl_step.sv]
// Next-state and result logic of the keypad scan sequencer for one tick word.
// Depends on kscl_pkg.
module kscl_step (
  input  kscl_pkg::ctrl_t   cur,
  input  kscl_pkg::cfg_t    cfg,
  input  logic [3:0]        lines,
  input  logic              match,
  output kscl_pkg::ctrl_t   nxt,
  output kscl_pkg::result_t res,
  output kscl_pkg::key_wr_t wr
);

  logic [7:0] timer_inc;
  logic [3:0] count_inc;
  logic [3:0] idx;
  logic       idle;

  assign timer_inc = (cur.tick_timer != kscl_pkg::TIMER_MAX) ? cur.tick_timer + 8'd1
                                                              : cur.tick_timer;
  assign count_inc = cur.key_count + 4'd1;
  assign idx       = {cur.row_number, ~cur.column_number};
  assign idle      = (lines == kscl_pkg::LINES_IDLE);

  always_comb begin
    nxt              = cur;
    res              = '0;
    res.keys_entered = cur.key_count;
    wr.wr_en         = 1'b0;
    wr.slot          = cur.key_count[kscl_pkg::SLOT_W-1:0];
    wr.key_idx       = idx;
    unique case (cur.phase)
      kscl_pkg::PH_RELEASE: begin
        if (idle) begin
          nxt.tick_timer = timer_inc;
          if (timer_inc >= cfg.release_settle_ticks) begin
            nxt.phase      = kscl_pkg::PH_PRESS;
            nxt.tick_timer = '0;
          end
        end else begin
          nxt.tick_timer = '0;
        end
      end
      kscl_pkg::PH_PRESS: begin
        if (!idle) begin
          nxt.column_number = kscl_pkg::decode_column(lines);
          nxt.phase         = kscl_pkg::PH_DEBOUNCE;
          nxt.tick_timer    = '0;
        end
      end
      kscl_pkg::PH_DEBOUNCE: begin
        nxt.tick_timer = timer_inc;
        if (timer_inc >= cfg.debounce_ticks) begin
          nxt.tick_timer = '0;
          if (idle) begin
            nxt.phase = kscl_pkg::PH_RELEASE;
          end else begin
            nxt.column_number = kscl_pkg::decode_column(lines);
            nxt.row_number    = '0;
            nxt.phase         = kscl_pkg::PH_SCAN;
          end
        end
      end
      kscl_pkg::PH_SCAN: begin
        res.row_drive  = ~(4'b0001 << cur.row_number);
        nxt.tick_timer = timer_inc;
        if (timer_inc >= cfg.row_settle_ticks) begin
          nxt.tick_timer = '0;
          if (!idle) begin
            res.key_valid    = 1'b1;
            res.key_char     = kscl_pkg::key_char(idx);
            res.keys_entered = count_inc;
            wr.wr_en         = 1'b1;
            nxt.key_count    = count_inc;
            nxt.phase        = kscl_pkg::PH_RELEASE;
            if (count_inc >= 4'(kscl_pkg::CODE_LENGTH)) begin
              res.entry_done     = 1'b1;
              res.access_granted = match;
              nxt.key_count      = '0;
            end
          end else if (cur.row_number == kscl_pkg::LAST_ROW) begin
            // no row pulled a column low
            nxt.row_number = '0;
            nxt.phase      = kscl_pkg::PH_RELEASE;
          end else begin
            nxt.row_number = cur.row_number + 2'd1;
          end
        end
      end
      default: begin
        nxt.phase = kscl_pkg::PH_RELEASE;
      end
    endcase
  end

endmodule

[hw/rtl/keypad_scanner_code_lock_unit.sv]
// Top level of the keypad scanner code lock: configuration registers,
// sequencer state and result register. Depends on kscl_pkg, kscl_step, kscl_key_store.
//
// Each input word is one millisecond tick carrying the four active-low column
// lines of a 4x4 keypad; each accepted word yields exactly one result word with
// the row drive for that tick, any key identified (ASCII), the count of keys
// collected and, on the eighth key, the granted/denied verdict against the
// passcode. A word is taken every clock cycle unless the output stalls: the
// sequencer state and the result register both load on the accepting edge, so
// the result appears in the cycle after, and a new word is accepted while the
// previous result waits, provided the result register is free or being drained
// in the same cycle. Configuration writes are always accepted and take effect
// on the next word; writes should only be made while no result is pending.
module keypad_scanner_code_lock_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [3:0]  in_column_lines,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  out_row_drive,
  output logic        out_key_valid,
  output logic [7:0]  out_key_char,
  output logic [3:0]  out_keys_entered,
  output logic        out_entry_done,
  output logic        out_access_granted,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  kscl_pkg::cfg_t    cfg_r;
  kscl_pkg::ctrl_t   ctrl_r, ctrl_nxt;
  kscl_pkg::result_t res_r, res_nxt;
  kscl_pkg::key_wr_t key_wr;
  logic              out_valid_r;
  logic              match;
  logic              in_fire;

  assign cfg_ready = 1'b1;
  assign in_ready  = !out_valid_r || out_ready;
  assign in_fire   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.passcode             <= kscl_pkg::PASSCODE_RST;
      cfg_r.release_settle_ticks <= kscl_pkg::RELEASE_SETTLE_RST;
      cfg_r.debounce_ticks       <= kscl_pkg::DEBOUNCE_RST;
      cfg_r.row_settle_ticks     <= kscl_pkg::ROW_SETTLE_RST;
    end else if (cfg_valid) begin
      unique case (kscl_pkg::reg_idx_t'(cfg_index))
        kscl_pkg::REG_PASSCODE:       cfg_r.passcode             <= cfg_data;
        kscl_pkg::REG_RELEASE_SETTLE: cfg_r.release_settle_ticks <= cfg_data[7:0];
        kscl_pkg::REG_DEBOUNCE:       cfg_r.debounce_ticks       <= cfg_data[7:0];
        kscl_pkg::REG_ROW_SETTLE:     cfg_r.row_settle_ticks     <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  kscl_step u_step (
    .cur   (ctrl_r),
    .cfg   (cfg_r),
    .lines (in_column_lines),
    .match (match),
    .nxt   (ctrl_nxt),
    .res   (res_nxt),
    .wr    (key_wr)
  );

  kscl_key_store u_key_store (
    .clk      (clk),
    .wr_fire  (in_fire && key_wr.wr_en),
    .wr       (key_wr),
    .passcode (cfg_r.passcode),
    .match    (match)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctrl_r.phase         <= kscl_pkg::PH_RELEASE;
      ctrl_r.tick_timer    <= '0;
      ctrl_r.column_number <= '0;
      ctrl_r.row_number    <= '0;
      ctrl_r.key_count     <= '0;
      out_valid_r          <= 1'b0;
    end else begin
      if (in_fire) begin
        ctrl_r <= ctrl_nxt;
      end
      if (in_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_row_drive      = res_r.row_drive;
  assign out_key_valid      = res_r.key_valid;
  assign out_key_char       = res_r.key_char;
  assign out_keys_entered   = res_r.keys_entered;
  assign out_entry_done     = res_r.entry_done;
  assign out_access_granted = res_r.access_granted;

endmodule
